[hw/rtl/npc_pkg.sv]
package npc_pkg;

    localparam int MAX_BOARD_DEF = 16;
    localparam int BOARD_W       = 5;
    localparam int KIND_W        = 2;
    localparam int COUNT_W       = 45;

    typedef logic [COUNT_W-1:0] t_count;

    localparam t_count COUNT_MAX = '1;
    localparam t_count COUNT_ONE = t_count'(1);

    typedef enum logic [KIND_W-1:0] {
        PK_ROOK   = 2'd0,
        PK_QUEEN  = 2'd1,
        PK_AMAZON = 2'd2,
        PK_KNIGHT = 2'd3
    } t_piece;

    typedef enum logic [1:0] {
        TS_IDLE,
        TS_ROOK,
        TS_QUEEN,
        TS_KNIGHT
    } t_top_state;

    typedef enum logic [2:0] {
        QS_IDLE,
        QS_PICK,
        QS_ROOT,
        QS_STEP,
        QS_POP
    } t_q_state;

    typedef enum logic [2:0] {
        KS_IDLE,
        KS_INIT,
        KS_ROW,
        KS_DRAIN,
        KS_SUM,
        KS_SUMEND
    } t_k_state;

    // Status an engine hands back to the top level.
    typedef struct packed {
        logic   done;
        t_count count;
    } t_eng_rsp;

    // Add that sticks at the largest count instead of wrapping.
    function automatic t_count sat_add(t_count a, t_count b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

endpackage

[hw/rtl/nonattacking_piece_placement_counter_unit.sv]
// Counts the ways to put one piece in every row of a square board so that no
// two pieces attack each other. A request is taken when start is high while
// busy is low; busy then stays high until the count appears on
// o_solution_count together with a one-cycle o_valid strobe, and the strobe
// beat cannot be held off by the receiver. A new request may be issued in the
// strobe cycle. Run time depends on the piece kind and the board size n
// (sizes above MAX_BOARD count as MAX_BOARD, size 0 always gives 1):
// rooks are set by one saturating multiply per row; knights are set by the
// single read port of the count table (one table read per cycle); queens
// and amazons are set by the backtracking walk over the frame stack memory,
// and their run time grows exponentially with n. Counts that would pass
// 2^45 - 1 stick at 2^45 - 1.
module nonattacking_piece_placement_counter_unit #(
    parameter int MAX_BOARD = npc_pkg::MAX_BOARD_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic [npc_pkg::BOARD_W-1:0]    i_board_size,
    input  logic [npc_pkg::KIND_W-1:0]     i_piece_kind,
    output logic                           busy,
    output logic                           o_valid,
    output logic [npc_pkg::COUNT_W-1:0]    o_solution_count
);

    localparam int NW = $clog2(MAX_BOARD + 1);

    npc_pkg::t_top_state r_state, n_state;
    logic [NW-1:0]       r_n, n_n;
    logic [NW:0]         r_i, n_i;
    npc_pkg::t_count     r_f, n_f;
    logic                r_valid, n_valid;
    npc_pkg::t_count     r_out, n_out;

    logic [NW-1:0]                   n_clamped;
    logic [npc_pkg::COUNT_W+NW:0]    rook_prod;
    npc_pkg::t_count                 rook_next;
    logic                            accept;
    logic                            q_start, q_amazon, k_start;
    npc_pkg::t_eng_rsp               q_rsp, k_rsp;

    // Board sizes beyond what the engines are built for are clamped.
    assign n_clamped = (i_board_size > npc_pkg::BOARD_W'(MAX_BOARD))
                     ? NW'(MAX_BOARD) : NW'(i_board_size);
    assign accept    = start && (r_state == npc_pkg::TS_IDLE);

    // Rooks: the count is n factorial, built one factor per cycle. Once the
    // product sticks at the top it stays there, since every factor is >= 2.
    assign rook_prod = {{(NW+1){1'b0}}, r_f} * {{npc_pkg::COUNT_W{1'b0}}, r_i};
    assign rook_next = (|rook_prod[npc_pkg::COUNT_W+NW:npc_pkg::COUNT_W])
                     ? npc_pkg::COUNT_MAX : rook_prod[npc_pkg::COUNT_W-1:0];

    // Queens and amazons share the backtracking engine; the amazon flag adds
    // the knight exclusions against the two rows above.
    assign q_start  = accept && ((npc_pkg::t_piece'(i_piece_kind) == npc_pkg::PK_QUEEN)
                              || (npc_pkg::t_piece'(i_piece_kind) == npc_pkg::PK_AMAZON));
    assign q_amazon = (npc_pkg::t_piece'(i_piece_kind) == npc_pkg::PK_AMAZON);
    assign k_start  = accept && (npc_pkg::t_piece'(i_piece_kind) == npc_pkg::PK_KNIGHT);

    npc_qsearch #(
        .MAX_BOARD (MAX_BOARD)
    ) u_qsearch (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (q_start),
        .i_amazon (q_amazon),
        .i_n      (n_clamped),
        .o_rsp    (q_rsp)
    );

    // Knights only ever interact with the two rows above, so the count is
    // carried row by row in a table indexed by those two columns.
    npc_kdp #(
        .MAX_BOARD (MAX_BOARD)
    ) u_kdp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (k_start),
        .i_n     (n_clamped),
        .o_rsp   (k_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npc_pkg::TS_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_i   <= n_i;
        r_f   <= n_f;
        r_out <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_f     = r_f;
        n_out   = r_out;
        n_valid = 1'b0;

        unique case (r_state)
            npc_pkg::TS_IDLE: begin
                if (start) begin
                    n_n = n_clamped;
                    unique case (npc_pkg::t_piece'(i_piece_kind))
                        npc_pkg::PK_ROOK: begin
                            n_f     = npc_pkg::COUNT_ONE;
                            n_i     = (NW+1)'(2);
                            n_state = npc_pkg::TS_ROOK;
                        end
                        npc_pkg::PK_QUEEN, npc_pkg::PK_AMAZON: begin
                            n_state = npc_pkg::TS_QUEEN;
                        end
                        npc_pkg::PK_KNIGHT: begin
                            n_state = npc_pkg::TS_KNIGHT;
                        end
                        default: begin
                            n_state = npc_pkg::TS_IDLE;
                        end
                    endcase
                end
            end
            npc_pkg::TS_ROOK: begin
                if (r_i > {1'b0, r_n}) begin
                    n_out   = r_f;
                    n_valid = 1'b1;
                    n_state = npc_pkg::TS_IDLE;
                end else begin
                    n_f = rook_next;
                    n_i = r_i + (NW+1)'(1);
                end
            end
            npc_pkg::TS_QUEEN: begin
                if (q_rsp.done) begin
                    n_out   = q_rsp.count;
                    n_valid = 1'b1;
                    n_state = npc_pkg::TS_IDLE;
                end
            end
            npc_pkg::TS_KNIGHT: begin
                if (k_rsp.done) begin
                    n_out   = k_rsp.count;
                    n_valid = 1'b1;
                    n_state = npc_pkg::TS_IDLE;
                end
            end
            default: begin
                n_state = npc_pkg::TS_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != npc_pkg::TS_IDLE);
    assign o_valid          = r_valid;
    assign o_solution_count = r_out;

endmodule

[hw/rtl/npc_qsearch.sv]
module npc_qsearch #(
    parameter int MAX_BOARD = npc_pkg::MAX_BOARD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_amazon,
    input  logic [$clog2(MAX_BOARD+1)-1:0]    i_n,
    output npc_pkg::t_eng_rsp                 o_rsp
);

    localparam int NW = $clog2(MAX_BOARD + 1);
    localparam int IW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
    localparam int FW = 5 * MAX_BOARD;

    typedef logic [MAX_BOARD-1:0] t_mask;

    npc_pkg::t_q_state r_state, n_state;
    logic [NW-1:0]     r_n, n_n;
    logic              r_amz, n_amz;
    logic [IW-1:0]     r_c0, n_c0;
    logic              r_mid, n_mid;
    npc_pkg::t_count   r_cnt, n_cnt;
    logic [IW-1:0]     r_lvl, n_lvl;
    t_mask             r_cm, n_cm, r_ld, n_ld, r_rd, n_rd, r_av, n_av, r_pb, n_pb;
    logic              r_done, n_done;

    // One frame per row of the search: attacked columns, both diagonals,
    // columns still to try, and the column taken one row up.
    logic [FW-1:0] frame_mem [MAX_BOARD];
    logic [FW-1:0] r_q;
    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [FW-1:0] mem_wdata;

    t_mask         full, low, b0, root_av, dsc_cm, dsc_ld, dsc_rd, dsc_km, dsc_av;
    logic [NW-1:0] half;
    logic          search_end;

    always_comb begin
        for (int k = 0; k < MAX_BOARD; k++) begin
            full[k] = (k < int'(r_n));
        end
    end

    assign half    = r_n >> 1;
    assign low     = r_av & (~r_av + t_mask'(1));
    assign b0      = t_mask'(1) << r_c0;
    assign root_av = full & ~(b0 | (b0 << 1) | (b0 >> 1))
                   & ~(r_amz ? ((b0 << 2) | (b0 >> 2)) : '0);
    assign dsc_cm  = r_cm | low;
    assign dsc_ld  = ((r_ld | low) << 1) & full;
    assign dsc_rd  = (r_rd | low) >> 1;
    assign dsc_km  = r_amz ? ((low << 2) | (low >> 2) | (r_pb << 1) | (r_pb >> 1)) : '0;
    assign dsc_av  = full & ~(dsc_cm | dsc_ld | dsc_rd | dsc_km);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        r_q <= frame_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npc_pkg::QS_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
            r_lvl   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
            r_lvl   <= n_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_amz <= n_amz;
        r_c0  <= n_c0;
        r_mid <= n_mid;
        r_cm  <= n_cm;
        r_ld  <= n_ld;
        r_rd  <= n_rd;
        r_av  <= n_av;
        r_pb  <= n_pb;
    end

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_amz      = r_amz;
        n_c0       = r_c0;
        n_mid      = r_mid;
        n_cnt      = r_cnt;
        n_lvl      = r_lvl;
        n_cm       = r_cm;
        n_ld       = r_ld;
        n_rd       = r_rd;
        n_av       = r_av;
        n_pb       = r_pb;
        n_done     = 1'b0;
        search_end = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = r_lvl;
        mem_wdata  = {r_cm, r_ld, r_rd, r_av ^ low, r_pb};
        mem_raddr  = r_lvl - IW'(1);

        unique case (r_state)
            npc_pkg::QS_IDLE: begin
                if (i_start) begin
                    n_n   = i_n;
                    n_amz = i_amazon;
                    n_c0  = '0;
                    n_mid = 1'b0;
                    n_cnt = '0;
                    if (i_n == '0) begin
                        n_cnt  = npc_pkg::COUNT_ONE;
                        n_done = 1'b1;
                    end else begin
                        n_state = npc_pkg::QS_PICK;
                    end
                end
            end
            npc_pkg::QS_PICK: begin
                if (!r_mid && (NW'(r_c0) != half)) begin
                    n_state = npc_pkg::QS_ROOT;
                end else if (!r_mid) begin
                    // Left half done: count it twice for the mirror image.
                    n_cnt = npc_pkg::sat_add(r_cnt, r_cnt);
                    n_mid = 1'b1;
                    if (r_n[0]) begin
                        n_state = npc_pkg::QS_ROOT;
                    end else begin
                        n_state = npc_pkg::QS_IDLE;
                        n_done  = 1'b1;
                    end
                end else begin
                    n_state = npc_pkg::QS_IDLE;
                    n_done  = 1'b1;
                end
            end
            npc_pkg::QS_ROOT: begin
                if (r_n == NW'(1)) begin
                    n_cnt      = npc_pkg::sat_add(r_cnt, npc_pkg::COUNT_ONE);
                    search_end = 1'b1;
                end else begin
                    n_cm    = b0;
                    n_ld    = (b0 << 1) & full;
                    n_rd    = b0 >> 1;
                    n_av    = root_av;
                    n_pb    = b0;
                    n_lvl   = IW'(1);
                    n_state = npc_pkg::QS_STEP;
                end
            end
            npc_pkg::QS_STEP: begin
                if (r_av == '0) begin
                    if (r_lvl == IW'(1)) begin
                        search_end = 1'b1;
                    end else begin
                        n_state = npc_pkg::QS_POP;
                    end
                end else if (NW'(r_lvl) == r_n - NW'(1)) begin
                    n_av  = r_av ^ low;
                    n_cnt = npc_pkg::sat_add(r_cnt, npc_pkg::COUNT_ONE);
                end else begin
                    mem_we = 1'b1;
                    n_cm   = dsc_cm;
                    n_ld   = dsc_ld;
                    n_rd   = dsc_rd;
                    n_av   = dsc_av;
                    n_pb   = low;
                    n_lvl  = r_lvl + IW'(1);
                end
            end
            npc_pkg::QS_POP: begin
                {n_cm, n_ld, n_rd, n_av, n_pb} = r_q;
                n_lvl   = r_lvl - IW'(1);
                n_state = npc_pkg::QS_STEP;
            end
            default: begin
                n_state = npc_pkg::QS_IDLE;
            end
        endcase

        if (search_end) begin
            if (!r_mid) begin
                n_c0 = r_c0 + IW'(1);
            end
            n_state = npc_pkg::QS_PICK;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.count = r_cnt;

endmodule

[hw/rtl/npc_kdp.sv]
module npc_kdp #(
    parameter int MAX_BOARD = npc_pkg::MAX_BOARD_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [$clog2(MAX_BOARD+1)-1:0]    i_n,
    output npc_pkg::t_eng_rsp                 o_rsp
);

    localparam int NW = $clog2(MAX_BOARD + 1);
    localparam int IW = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
    localparam int AW = 2 * IW + 1;

    function automatic logic [IW:0] adiff(logic [IW-1:0] x, logic [IW-1:0] y);
        return (x > y) ? {1'b0, x - y} : {1'b0, y - x};
    endfunction

    npc_pkg::t_k_state r_state, n_state;
    logic [NW-1:0]     r_n, n_n;
    logic [NW-1:0]     r_row, n_row;
    logic              r_bank, n_bank;
    logic [IW-1:0]     r_a, n_a, r_b, n_b, r_c, n_c;
    logic              r_pv, n_pv, r_pfirst, n_pfirst, r_plast, n_plast;
    logic              r_puse, n_puse, r_pwr, n_pwr;
    logic [IW-1:0]     r_pb, n_pb, r_pc, n_pc;
    npc_pkg::t_count   r_acc, n_acc, r_res, n_res;
    logic              r_done, n_done;

    // Two banks of counts indexed by the columns of the last two rows; one is
    // read while the other is written, and they swap after every row.
    npc_pkg::t_count dp_mem [2**AW];
    npc_pkg::t_count r_q;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    npc_pkg::t_count mem_wdata;

    logic [IW-1:0]   nm1;
    npc_pkg::t_count acc_sum;

    assign nm1     = IW'(r_n - NW'(1));
    assign acc_sum = npc_pkg::sat_add(r_pfirst ? '0 : r_acc, r_puse ? r_q : '0);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            dp_mem[mem_waddr] <= mem_wdata;
        end
        r_q <= dp_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npc_pkg::KS_IDLE;
            r_done  <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_row    <= n_row;
        r_bank   <= n_bank;
        r_a      <= n_a;
        r_b      <= n_b;
        r_c      <= n_c;
        r_pfirst <= n_pfirst;
        r_plast  <= n_plast;
        r_puse   <= n_puse;
        r_pwr    <= n_pwr;
        r_pb     <= n_pb;
        r_pc     <= n_pc;
        r_acc    <= n_acc;
        r_res    <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_row     = r_row;
        n_bank    = r_bank;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_pv      = 1'b0;
        n_pfirst  = r_pfirst;
        n_plast   = r_plast;
        n_puse    = r_puse;
        n_pwr     = r_pwr;
        n_pb      = r_pb;
        n_pc      = r_pc;
        n_acc     = r_acc;
        n_res     = r_res;
        n_done    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = {~r_bank, r_pb, r_pc};
        mem_wdata = acc_sum;
        mem_raddr = {r_bank, r_a, r_b};

        // Accumulate stage: one read beat per cycle, written out at the last a.
        if (r_pv) begin
            n_acc = acc_sum;
            if (r_pwr && r_plast) begin
                mem_we = 1'b1;
            end
        end

        unique case (r_state)
            npc_pkg::KS_IDLE: begin
                if (i_start) begin
                    n_n    = i_n;
                    n_a    = '0;
                    n_b    = '0;
                    n_c    = '0;
                    n_bank = 1'b0;
                    if (i_n <= NW'(1)) begin
                        n_res  = npc_pkg::COUNT_ONE;
                        n_done = 1'b1;
                    end else begin
                        n_state = npc_pkg::KS_INIT;
                    end
                end
            end
            npc_pkg::KS_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = {r_bank, r_a, r_b};
                mem_wdata = (adiff(r_a, r_b) != (IW+1)'(2)) ? npc_pkg::COUNT_ONE : '0;
                n_b       = r_b + IW'(1);
                if (r_b == nm1) begin
                    n_b = '0;
                    n_a = r_a + IW'(1);
                    if (r_a == nm1) begin
                        n_a     = '0;
                        n_row   = NW'(2);
                        n_state = (r_n == NW'(2)) ? npc_pkg::KS_SUM : npc_pkg::KS_ROW;
                    end
                end
            end
            npc_pkg::KS_ROW: begin
                n_pv     = 1'b1;
                n_pfirst = (r_a == '0);
                n_plast  = (r_a == nm1);
                n_puse   = (adiff(r_b, r_c) != (IW+1)'(2))
                        && (adiff(r_a, r_c) != (IW+1)'(1));
                n_pwr    = 1'b1;
                n_pb     = r_b;
                n_pc     = r_c;
                n_a      = r_a + IW'(1);
                if (r_a == nm1) begin
                    n_a = '0;
                    n_c = r_c + IW'(1);
                    if (r_c == nm1) begin
                        n_c = '0;
                        n_b = r_b + IW'(1);
                        if (r_b == nm1) begin
                            n_b     = '0;
                            n_state = npc_pkg::KS_DRAIN;
                        end
                    end
                end
            end
            npc_pkg::KS_DRAIN: begin
                n_bank = ~r_bank;
                if (r_row == r_n - NW'(1)) begin
                    n_state = npc_pkg::KS_SUM;
                end else begin
                    n_row   = r_row + NW'(1);
                    n_state = npc_pkg::KS_ROW;
                end
            end
            npc_pkg::KS_SUM: begin
                n_pv     = 1'b1;
                n_pfirst = (r_a == '0) && (r_b == '0);
                n_plast  = (r_a == nm1) && (r_b == nm1);
                n_puse   = 1'b1;
                n_pwr    = 1'b0;
                n_b      = r_b + IW'(1);
                if (r_b == nm1) begin
                    n_b = '0;
                    n_a = r_a + IW'(1);
                    if (r_a == nm1) begin
                        n_a     = '0;
                        n_state = npc_pkg::KS_SUMEND;
                    end
                end
            end
            npc_pkg::KS_SUMEND: begin
                n_res   = acc_sum;
                n_done  = 1'b1;
                n_state = npc_pkg::KS_IDLE;
            end
            default: begin
                n_state = npc_pkg::KS_IDLE;
            end
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.count = r_res;

endmodule

[hw/rtl/npc_checker.sv]
module npc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    // A taken request keeps the block busy in the next cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // The result beat comes exactly when busy ends.
    a_valid_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("result beat outside the end of a request");

    a_end_gives_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("request ended without a result beat");

    // One beat per request: two strobes never run back to back.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind nonattacking_piece_placement_counter_unit npc_checker u_npc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

[test/tb_nonattacking_piece_placement_counter_unit.sv]
module tb_nonattacking_piece_placement_counter_unit;

    import npc_pkg::*;

    // The largest side the block searches; bigger requests fold down to it.
    localparam int MAX_SIDE = 16;

    // The slowest correct run is dominated by the two directed size-10 searches
    // (queen and amazon), the full-size knight tables and the random knights up
    // to size 12; the limit below leaves a wide margin above that run.
    localparam int CYCLE_LIMIT = 20_000_000;

    // After the last count arrives, give the block time to show any stray
    // strobe before the verdict.
    localparam int DRAIN_CYCLES = 64;

    // One outstanding request together with the count it must produce.
    typedef struct packed {
        logic [BOARD_W-1:0] size;
        t_piece             kind;
        t_count             count;
    } t_pending;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic [BOARD_W-1:0] i_board_size;
    logic [KIND_W-1:0]  i_piece_kind;
    logic               busy;
    logic               o_valid;
    logic [COUNT_W-1:0] o_solution_count;

    // Counts still owed by the block, oldest first.
    t_pending pending_counts[$];

    // Counts already worked out, indexed by piece kind and folded side.
    t_count memo_count [4][MAX_SIDE+1];
    bit     memo_valid [4][MAX_SIDE+1];

    int sender_idle_pct;
    int mismatches;
    int requests_sent;
    int counts_checked;
    int cycle_count;

    nonattacking_piece_placement_counter_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .i_board_size     (i_board_size),
        .i_piece_kind     (i_piece_kind),
        .busy             (busy),
        .o_valid          (o_valid),
        .o_solution_count (o_solution_count)
    );

    // 12 time unit clock, six high and six low.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog: a hung search ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d counts outstanding.",
                     cycle_count, pending_counts.size());
            $display("FAIL nonattacking_piece_placement_counter_unit");
            $finish;
        end
    end

    // Every mismatch goes through here: one line, one tick of the counter.
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    // Saturating add at the width of the count port.
    function automatic logic [63:0] capped_sum(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > 64'(COUNT_MAX)) ? 64'(COUNT_MAX) : s;
    endfunction

    function automatic int distance(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Rooks only clash on columns, so the count is n factorial.
    function automatic t_count count_rook_placements(input int n);
        logic [63:0] f;
        f = 1;
        for (int i = 2; i <= n; i++) begin
            f = f * i;
            if (f > 64'(COUNT_MAX))
                f = 64'(COUNT_MAX);
        end
        return t_count'(f);
    endfunction

    // Knights are counted row by row. The table is indexed by the columns of
    // the two rows above the one being added: a knight one row up must not sit
    // two columns off, and one two rows up must not sit one column off.
    function automatic t_count count_knight_rows(input int n);
        logic [63:0] ways      [MAX_SIDE][MAX_SIDE];
        logic [63:0] next_ways [MAX_SIDE][MAX_SIDE];
        logic [63:0] total;
        total = 0;
        if (n <= 1)
            return COUNT_ONE;
        for (int a = 0; a < n; a++)
            for (int b = 0; b < n; b++)
                ways[a][b] = (distance(a, b) != 2) ? 64'd1 : 64'd0;
        for (int r = 2; r < n; r++) begin
            for (int a = 0; a < n; a++)
                for (int b = 0; b < n; b++)
                    next_ways[a][b] = 0;
            for (int a = 0; a < n; a++)
                for (int b = 0; b < n; b++)
                    if (ways[a][b] != 0)
                        for (int c = 0; c < n; c++)
                            if (distance(b, c) != 2 && distance(a, c) != 1)
                                next_ways[b][c] = capped_sum(next_ways[b][c], ways[a][b]);
            for (int a = 0; a < n; a++)
                for (int b = 0; b < n; b++)
                    ways[a][b] = next_ways[a][b];
        end
        for (int a = 0; a < n; a++)
            for (int b = 0; b < n; b++)
                total = capped_sum(total, ways[a][b]);
        return t_count'(total);
    endfunction

    // Plain backtracking for queens, and for amazons when the knight moves are
    // also ruled out. Each row tries every column in turn and checks it against
    // all rows placed above it.
    function automatic t_count count_line_placements(input int n, input bit with_knight);
        int          col [MAX_SIDE];
        int          row;
        int          dr;
        int          dc;
        bit          clear;
        logic [63:0] found;
        if (n == 0)
            return COUNT_ONE;
        found  = 0;
        row    = 0;
        col[0] = 0;
        while (row >= 0) begin
            if (col[row] >= n) begin
                row--;
                if (row >= 0)
                    col[row]++;
            end else begin
                clear = 1'b1;
                for (int p = 0; p < row; p++) begin
                    dr = row - p;
                    dc = distance(col[row], col[p]);
                    if (dc == 0 || dc == dr)
                        clear = 1'b0;
                    if (with_knight && ((dr == 1 && dc == 2) || (dr == 2 && dc == 1)))
                        clear = 1'b0;
                end
                if (!clear) begin
                    col[row]++;
                end else if (row == n - 1) begin
                    found = capped_sum(found, 64'd1);
                    col[row]++;
                end else begin
                    row++;
                    col[row] = 0;
                end
            end
        end
        return t_count'(found);
    endfunction

    // Expected count for one request. Sizes past the largest board fold down
    // to it, and the empty board gives one placement for every kind.
    function automatic t_count predict_placements(input logic [BOARD_W-1:0] size,
                                                  input t_piece kind);
        int     side;
        t_count result;
        side = (size > MAX_SIDE) ? MAX_SIDE : int'(size);
        if (memo_valid[kind][side])
            return memo_count[kind][side];
        case (kind)
            PK_ROOK:   result = count_rook_placements(side);
            PK_QUEEN:  result = count_line_placements(side, 1'b0);
            PK_AMAZON: result = count_line_placements(side, 1'b1);
            default:   result = count_knight_rows(side);
        endcase
        memo_count[kind][side] = result;
        memo_valid[kind][side] = 1'b1;
        return result;
    endfunction

    // Sends one request beat. Called at a falling edge and returns at one, so
    // start can stay high straight into the next request. Sender gaps are
    // inserted before the beat according to the current idle percentage.
    task automatic send_request(input int side_field, input t_piece kind);
        t_pending item;
        item.size  = side_field[BOARD_W-1:0];
        item.kind  = kind;
        item.count = predict_placements(item.size, kind);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start        <= 1'b1;
        i_board_size <= item.size;
        i_piece_kind <= kind;
        // The beat is taken at the first rising edge that sees busy low.
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_counts.push_back(item);
        requests_sent++;
        @(negedge i_clk);
    endtask

    // Checks each count against the oldest outstanding request. The block
    // cannot be held off, so the strobe is sampled at every rising edge.
    always @(posedge i_clk) begin
        t_pending owed;
        if (i_rst_n && o_valid) begin
            if (pending_counts.size() == 0) begin
                report_mismatch($sformatf("count %0d arrived with no request outstanding",
                                          o_solution_count));
            end else begin
                owed = pending_counts.pop_front();
                counts_checked++;
                if (o_solution_count !== owed.count)
                    report_mismatch($sformatf("%s on size %0d: got %0d, want %0d",
                                              owed.kind.name(), owed.size,
                                              o_solution_count, owed.count));
            end
        end
    end

    // Size 0 must give exactly one placement whatever the piece.
    task automatic test_empty_board();
        send_request(0, PK_ROOK);
        send_request(0, PK_QUEEN);
        send_request(0, PK_AMAZON);
        send_request(0, PK_KNIGHT);
    endtask

    // Rook counts are factorials; 16 is the largest and still fits the port.
    task automatic test_rook_factorial();
        send_request(1, PK_ROOK);
        send_request(7, PK_ROOK);
        send_request(16, PK_ROOK);
    endtask

    // Queens include the sizes with no solution at all (2 and 3) and one
    // deeper search to exercise long backtracking.
    task automatic test_queen_search();
        send_request(1, PK_QUEEN);
        send_request(2, PK_QUEEN);
        send_request(3, PK_QUEEN);
        send_request(4, PK_QUEEN);
        send_request(10, PK_QUEEN);
    endtask

    // Amazons prune harder than queens, so small boards past size 1 come out empty.
    task automatic test_amazon_search();
        send_request(1, PK_AMAZON);
        send_request(4, PK_AMAZON);
        send_request(10, PK_AMAZON);
    endtask

    // Knights allow shared columns, so even size 2 has several placements.
    task automatic test_knight_rows();
        send_request(1, PK_KNIGHT);
        send_request(2, PK_KNIGHT);
        send_request(8, PK_KNIGHT);
    endtask

    // Sizes past 16 fold to 16. The full-size knight count is far past the
    // width of the port and must stick at the all-ones value.
    task automatic test_oversized_board();
        send_request(17, PK_ROOK);
        send_request(31, PK_ROOK);
        send_request(31, PK_KNIGHT);
    endtask

    // Random requests. Rooks are cheap at any size, so they take the whole
    // field range. Searches grow fast with size, so queens and amazons stay
    // small and knights only rarely go to full size.
    task automatic test_random_requests(input int count);
        t_piece kind;
        int     side;
        for (int i = 0; i < count; i++) begin
            kind = t_piece'($urandom_range(0, 3));
            case (kind)
                PK_ROOK:
                    side = $urandom_range(0, 31);
                PK_KNIGHT:
                    side = ($urandom_range(0, 39) == 0) ? $urandom_range(16, 31)
                                                        : $urandom_range(0, 12);
                default:
                    side = ($urandom_range(0, 9) == 0) ? 9 : $urandom_range(0, 8);
            endcase
            send_request(side, kind);
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_board_size    = '0;
        i_piece_kind    = '0;
        sender_idle_pct = 8;
        mismatches      = 0;
        requests_sent   = 0;
        counts_checked  = 0;
        cycle_count     = 0;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests run with the light sender gaps of the first phase.
        test_empty_board();
        test_rook_factorial();
        test_queen_search();
        test_amazon_search();
        test_knight_rows();
        test_oversized_board();

        // Three random phases: light gaps, heavy gaps, then back to back.
        test_random_requests(27);
        sender_idle_pct = 57;
        test_random_requests(26);
        sender_idle_pct = 0;
        test_random_requests(26);
        start <= 1'b0;

        while (pending_counts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests across rook, queen, amazon and knight, sizes 0 to 31,",
                 requests_sent);
        $display("with sender gaps of 8%%, 57%% and none; %0d counts checked, %0d mismatches.",
                 counts_checked, mismatches);
        if (mismatches == 0) begin
            $display("PASS nonattacking_piece_placement_counter_unit");
        end else begin
            $display("FAIL nonattacking_piece_placement_counter_unit");
        end
        $finish;
    end

endmodule
